>>> rtl/bpe_pkg.sv
// Shared types and constants for the Bezier patch evaluator.
package bpe_pkg;
   localparam int unsigned COORD_W = 32;
   localparam int unsigned NPTS    = 16;
   localparam int unsigned IDX_W   = 4;
   localparam int unsigned GRID_W  = 6;
   localparam int unsigned STEP_W  = 3;

   // step registers saturate here; GRID_W and the lerp width are sized for 2^MAX_STEPS
   localparam logic [STEP_W-1:0] MAX_STEPS = 3'd5;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   localparam logic CSR_U_STEPS = 1'b0;
   localparam logic CSR_V_STEPS = 1'b1;

   localparam logic [STEP_W-1:0] STEPS_RESET = 3'd3;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   // reset control net: x = -3 + 2u, y = 0, z = -3 + 2v (Q16.16)
   function automatic point_type default_point(input logic [IDX_W-1:0] idx);
      point_type p;
      p.x = coord_type'((-3 + 2 * int'(idx[1:0])) * 65536);
      p.y = '0;
      p.z = coord_type'((-3 + 2 * int'(idx[3:2])) * 65536);
      return p;
   endfunction
endpackage

>>> rtl/bezier_patch_evaluator_unit.sv
// Top level: bicubic Bezier patch evaluator over a control-point RAM.
// Sequence: an accepted evaluation runs through S_READ, S_ROWS, S_COL and S_DONE, and
//   rsp_valid is registered from S_DONE; writes and out-of-range evaluations report
//   in the next cycle. Busy holds while the 16 control points are read through the
//   single RAM read port, the six row and six column de Casteljau lerp steps run (each
//   an issue, then a write-back phase), and the result is loaded.
// Reset: synchronous; the RAM is first swept with the flat default grid, and
//   busy is high during that pass. Results cannot be stalled by the receiver.
module bezier_patch_evaluator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_cmd,
   input  logic [bpe_pkg::IDX_W-1:0]       req_point_index,
   input  logic signed [31:0]              req_coord_x,
   input  logic signed [31:0]              req_coord_y,
   input  logic signed [31:0]              req_coord_z,
   input  logic [bpe_pkg::GRID_W-1:0]      req_grid_u,
   input  logic [bpe_pkg::GRID_W-1:0]      req_grid_v,
   output logic                            rsp_valid,
   output logic signed [31:0]              rsp_pos_x,
   output logic signed [31:0]              rsp_pos_y,
   output logic signed [31:0]              rsp_pos_z,
   output logic                            rsp_bad_grid,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [bpe_pkg::STEP_W-1:0]      csr_wdata
);
   localparam int unsigned PW = 3 * bpe_pkg::COORD_W;
   localparam logic [bpe_pkg::STEP_W-1:0] SAT = bpe_pkg::MAX_STEPS;

   typedef enum logic [2:0] {S_INIT, S_IDLE, S_READ, S_ROWS, S_COL, S_DONE} state_type;

   state_type                       state_ff;
   logic [bpe_pkg::IDX_W-1:0]       cnt_ff;      // sweep / read address
   logic [2:0]                      rcnt_ff;     // lerp slot j in [1:0], write-back in [2]
   logic [1:0]                      pass_ff;
   logic [bpe_pkg::STEP_W-1:0]      u_steps_ff, v_steps_ff;
   logic [bpe_pkg::GRID_W-1:0]      gu_ff, gv_ff;
   logic                            rd_pend_ff;
   logic [bpe_pkg::IDX_W-1:0]       rd_slot_ff;
   bpe_pkg::point_type              net_ff [bpe_pkg::NPTS];
   bpe_pkg::point_type              rd_data;
   logic                            wr_en;
   logic [bpe_pkg::IDX_W-1:0]       wr_addr;
   bpe_pkg::point_type              wr_data;
   logic [bpe_pkg::IDX_W-1:0]       jdx;

   // 12 lerp lanes: 4 rows x 3 axes, each reduces t[j] = lerp(t[j], t[j+1])
   bpe_pkg::coord_type              la [12];
   bpe_pkg::coord_type              lb [12];
   bpe_pkg::coord_type              ly [12];
   logic [bpe_pkg::GRID_W-1:0]      lk;
   logic [bpe_pkg::STEP_W-1:0]      ls;
   logic                            bad;
   logic [bpe_pkg::STEP_W-1:0]      csr_sat;

   assign csr_sat = (csr_wdata > SAT) ? SAT : csr_wdata;
   assign bad = (7'(req_grid_u) > (7'd1 << v_steps_ff)) ||
                (7'(req_grid_v) > (7'd1 << u_steps_ff));
   assign jdx = {2'b00, rcnt_ff[1:0]};

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = bpe_pkg::default_point(cnt_ff);
      if (state_ff == S_INIT) begin
         wr_en = 1'b1;
      end else if (start && !busy && req_cmd == bpe_pkg::CMD_WRITE) begin
         wr_en   = 1'b1;
         wr_addr = req_point_index;
         wr_data = '{req_coord_x, req_coord_y, req_coord_z};
      end
   end

   bpe_ram #(.WIDTH(PW), .DEPTH(bpe_pkg::NPTS)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data,
      .rd_addr(cnt_ff), .rd_data
   );

   // rows during S_ROWS: lane r*3+a works on row r; lanes in S_COL use row 0 only
   always_comb begin
      lk = (state_ff == S_COL) ? gv_ff : gu_ff;
      ls = (state_ff == S_COL) ? u_steps_ff : v_steps_ff;
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 3; j++) begin
            la[r*3+j] = '0;
            lb[r*3+j] = '0;
         end
      end
      // each lane handles one (row, axis); iterate over j via rcnt_ff[1:0]
      for (int r = 0; r < 4; r++) begin
         la[r*3+0] = net_ff[bpe_pkg::IDX_W'(r*4) + jdx].x;
         lb[r*3+0] = net_ff[bpe_pkg::IDX_W'(r*4 + 1) + jdx].x;
         la[r*3+1] = net_ff[bpe_pkg::IDX_W'(r*4) + jdx].y;
         lb[r*3+1] = net_ff[bpe_pkg::IDX_W'(r*4 + 1) + jdx].y;
         la[r*3+2] = net_ff[bpe_pkg::IDX_W'(r*4) + jdx].z;
         lb[r*3+2] = net_ff[bpe_pkg::IDX_W'(r*4 + 1) + jdx].z;
      end
   end

   for (genvar g = 0; g < 12; g++) begin : g_lane
      bpe_lerp u_lerp (.clock, .a(la[g]), .b(lb[g]), .k(lk), .s(ls), .y_ff(ly[g]));
   end

   // Sequencing: each pass i takes j = 0..i-1 in turn (issue, then write back).
   // rcnt_ff[1:0] = j, rcnt_ff[2] = writeback phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         rcnt_ff      <= '0;
         pass_ff      <= '0;
         u_steps_ff   <= bpe_pkg::STEPS_RESET;
         v_steps_ff   <= bpe_pkg::STEPS_RESET;
         rd_pend_ff   <= 1'b0;
         rsp_valid    <= 1'b0;
         busy         <= 1'b1;
      end else begin
         // writes and out-of-range evaluations answer from S_IDLE, evaluations from S_DONE
         rsp_valid  <= ((state_ff == S_IDLE) && start &&
                        (req_cmd == bpe_pkg::CMD_WRITE || bad)) || (state_ff == S_DONE);
         rd_pend_ff <= (state_ff == S_READ);
         if (csr_we) begin
            if (csr_index == bpe_pkg::CSR_U_STEPS) u_steps_ff <= csr_sat;
            else                                   v_steps_ff <= csr_sat;
         end
         if (rd_pend_ff) net_ff[rd_slot_ff] <= rd_data;
         unique case (state_ff)
            S_INIT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == bpe_pkg::IDX_W'(bpe_pkg::NPTS - 1)) begin
                  state_ff <= S_IDLE;
                  busy     <= 1'b0;
               end
            end
            S_IDLE: begin
               cnt_ff <= '0;
               if (start) begin
                  rsp_pos_x    <= '0;
                  rsp_pos_y    <= '0;
                  rsp_pos_z    <= '0;
                  rsp_bad_grid <= (req_cmd == bpe_pkg::CMD_EVAL) && bad;
                  if (req_cmd == bpe_pkg::CMD_EVAL && !bad) begin
                     gu_ff    <= req_grid_u;
                     gv_ff    <= req_grid_v;
                     state_ff <= S_READ;
                     busy     <= 1'b1;
                  end
               end
            end
            S_READ: begin
               rd_slot_ff <= cnt_ff;
               cnt_ff     <= cnt_ff + 1'b1;
               if (cnt_ff == bpe_pkg::IDX_W'(bpe_pkg::NPTS - 1)) begin
                  state_ff <= S_ROWS;
                  rcnt_ff  <= '0;
                  pass_ff  <= 2'd3;
               end
            end
            S_ROWS, S_COL: begin
               if (!rcnt_ff[2]) begin
                  rcnt_ff[2] <= 1'b1;
               end else begin
                  for (int r = 0; r < 4; r++) begin
                     net_ff[bpe_pkg::IDX_W'(r*4) + jdx] <=
                        '{ly[r*3+0], ly[r*3+1], ly[r*3+2]};
                  end
                  if (rcnt_ff[1:0] + 2'd1 == pass_ff) begin
                     rcnt_ff <= '0;
                     if (pass_ff == 2'd1) begin
                        if (state_ff == S_ROWS) begin
                           // row results form the column in slots 0..3; slot 0 is
                           // written by the lane loop above
                           for (int r = 1; r < 4; r++) begin
                              net_ff[bpe_pkg::IDX_W'(r)] <=
                                 '{ly[r*3+0], ly[r*3+1], ly[r*3+2]};
                           end
                           state_ff  <= S_COL;
                           pass_ff   <= 2'd3;
                        end else begin
                           state_ff <= S_DONE;
                        end
                     end else begin
                        pass_ff <= pass_ff - 2'd1;
                     end
                  end else begin
                     rcnt_ff <= {1'b0, rcnt_ff[1:0] + 2'd1};
                  end
               end
            end
            S_DONE: begin
               rsp_pos_x <= net_ff[0].x;
               rsp_pos_y <= net_ff[0].y;
               rsp_pos_z <= net_ff[0].z;
               busy      <= 1'b0;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   ap_busy_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> busy) else $error("busy low during init sweep");
   ap_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid || $past(state_ff == S_IDLE))
      else $error("unexpected back-to-back response");
   ap_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_grid) |-> (rsp_pos_x == 0 && rsp_pos_z == 0))
      else $error("bad grid with nonzero position");
   ap_steps_sat: assert property (@(posedge clock) disable iff (reset)
      (u_steps_ff <= SAT) && (v_steps_ff <= SAT)) else $error("step register over limit");
endmodule

>>> rtl/bpe_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module bpe_ram #(
   parameter int unsigned WIDTH = 96,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/bpe_lerp.sv
// One registered interpolation a + (((b - a) * k) >> s), floor shift.
module bpe_lerp (
   input  logic                               clock,
   input  bpe_pkg::coord_type                 a,
   input  bpe_pkg::coord_type                 b,
   input  logic [bpe_pkg::GRID_W-1:0]         k,
   input  logic [bpe_pkg::STEP_W-1:0]         s,
   output bpe_pkg::coord_type                 y_ff
);
   logic signed [bpe_pkg::COORD_W:0]    diff;
   logic signed [bpe_pkg::COORD_W+7:0]  prod;
   logic signed [bpe_pkg::COORD_W+7:0]  shifted;
   logic signed [bpe_pkg::COORD_W+7:0]  sum;
   bpe_pkg::coord_type                  y_in;

   always_comb begin
      diff    = {b[bpe_pkg::COORD_W-1], b} - {a[bpe_pkg::COORD_W-1], a};
      prod    = diff * $signed({1'b0, k});
      shifted = prod >>> s;
      sum     = shifted + (bpe_pkg::COORD_W+8)'(a);
      y_in    = sum[bpe_pkg::COORD_W-1:0];
   end

   always_ff @(posedge clock) y_ff <= y_in;
endmodule
